/* src/qsb_pkg.sv */
// Package for the quad SPI bus bridge: payload types, phase codes and request codes.
package qsb_pkg;

    localparam int PHASE_W = 6;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 6'd0;
    localparam logic [PHASE_W-1:0] PH_SELECT = 6'd1;
    localparam logic [PHASE_W-1:0] PH_CMD    = 6'd2;
    localparam logic [PHASE_W-1:0] PH_ADDR   = 6'd18;
    localparam logic [PHASE_W-1:0] PH_DUMMY  = 6'd26;
    localparam logic [PHASE_W-1:0] PH_DATA   = 6'd28;
    localparam logic [PHASE_W-1:0] PH_DONE   = 6'd44;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [7:0] COMMAND_RESET = 8'd235;

    typedef struct packed {
        logic [1:0]  request_kind;
        logic [15:0] request_address;
        logic [31:0] write_word;
        logic [3:0]  miso_lanes;
    } t_in;

    typedef struct packed {
        logic        chip_select_n;
        logic        serial_clock;
        logic [3:0]  mosi_lanes;
        logic        bus_busy;
        logic        bus_done;
        logic [31:0] read_word;
    } t_out;

endpackage

/* src/qsb_core.sv */
// Frame sequencer: phase state, command register and per-tick lane logic.
module qsb_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  qsb_pkg::t_in     i_item,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    output qsb_pkg::t_out    o_result
);

    logic [qsb_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic                        r_is_write, n_is_write;
    logic [15:0]                 r_addr, n_addr;
    logic [31:0]                 r_data, n_data;
    logic                        r_polarity, n_polarity;
    logic                        r_sel_low, n_sel_low;
    logic [7:0]                  r_command;

    logic [qsb_pkg::PHASE_W-1:0] w_p;
    logic [qsb_pkg::PHASE_W-1:0] w_off_cmd, w_off_addr, w_off_data;
    logic                        w_start;
    logic [2:0]                  w_cmd_bit;
    logic [1:0]                  w_addr_nib;
    logic [2:0]                  w_data_nib;

    always_comb begin
        w_p = (r_phase > qsb_pkg::PH_DONE) ? qsb_pkg::PH_IDLE : r_phase;
        w_start = (w_p == qsb_pkg::PH_IDLE) &&
                  ((i_item.request_kind == qsb_pkg::REQ_READ) ||
                   (i_item.request_kind == qsb_pkg::REQ_WRITE));
        n_is_write = r_is_write;
        n_addr     = r_addr;
        n_data     = r_data;
        // latch the request when a frame opens
        if (w_start) begin
            w_p        = qsb_pkg::PH_SELECT;
            n_is_write = (i_item.request_kind == qsb_pkg::REQ_WRITE);
            n_addr     = i_item.request_address;
            n_data     = (i_item.request_kind == qsb_pkg::REQ_WRITE) ?
                         i_item.write_word : 32'd0;
        end

        w_off_cmd  = w_p - qsb_pkg::PH_CMD;
        w_off_addr = w_p - qsb_pkg::PH_ADDR;
        w_off_data = w_p - qsb_pkg::PH_DATA;
        w_cmd_bit  = ~w_off_cmd[3:1];
        w_addr_nib = ~w_off_addr[2:1];
        w_data_nib = ~w_off_data[3:1];

        o_result.chip_select_n = 1'b1;
        o_result.serial_clock  = 1'b0;
        o_result.mosi_lanes    = 4'd0;
        o_result.bus_busy      = 1'b0;
        o_result.bus_done      = 1'b0;
        o_result.read_word     = 32'd0;
        n_phase = qsb_pkg::PH_IDLE;

        if ((w_p >= qsb_pkg::PH_SELECT) && (w_p < qsb_pkg::PH_DONE)) begin
            o_result.chip_select_n = 1'b0;
            o_result.bus_busy      = 1'b1;
            n_phase = w_p + 6'd1;
            priority if ((w_p >= qsb_pkg::PH_CMD) && (w_p < qsb_pkg::PH_ADDR)) begin
                o_result.mosi_lanes = {3'd0, r_command[w_cmd_bit]};
            end else if ((w_p >= qsb_pkg::PH_ADDR) && (w_p < qsb_pkg::PH_DUMMY)) begin
                o_result.mosi_lanes = n_addr[{w_addr_nib, 2'b00} +: 4];
            end else if ((w_p >= qsb_pkg::PH_DUMMY) && (w_p < qsb_pkg::PH_DATA)) begin
                o_result.mosi_lanes = n_addr[3:0];
            end else if (w_p >= qsb_pkg::PH_DATA) begin
                if (n_is_write) begin
                    o_result.mosi_lanes = n_data[{w_data_nib, 2'b00} +: 4];
                end else begin
                    o_result.mosi_lanes = n_addr[3:0];
                    // sample on the first tick of each data beat
                    if (!w_off_data[0]) begin
                        n_data[{w_data_nib, 2'b00} +: 4] = i_item.miso_lanes;
                    end
                end
            end
        end else if (w_p == qsb_pkg::PH_DONE) begin
            o_result.bus_done  = 1'b1;
            o_result.read_word = n_is_write ? 32'd0 : n_data;
        end

        n_polarity = r_polarity;
        if (r_sel_low) begin
            n_polarity = ~r_polarity;
            o_result.serial_clock = n_polarity;
        end
        n_sel_low = ~o_result.chip_select_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= qsb_pkg::PH_IDLE;
            r_is_write <= 1'b0;
            r_addr     <= 16'd0;
            r_data     <= 32'd0;
            r_polarity <= 1'b0;
            r_sel_low  <= 1'b0;
            r_command  <= qsb_pkg::COMMAND_RESET;
        end else begin
            if (i_fire) begin
                r_phase    <= n_phase;
                r_is_write <= n_is_write;
                r_addr     <= n_addr;
                r_data     <= n_data;
                r_polarity <= n_polarity;
                r_sel_low  <= n_sel_low;
            end
            if (i_cfg_we) begin
                r_command <= i_cfg_wdata;
            end
        end
    end

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= qsb_pkg::PH_DONE)
        else $error("phase out of range");
    a_sel_tracks_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (n_phase != qsb_pkg::PH_IDLE) && (n_phase != qsb_pkg::PH_DONE)
        |=> r_sel_low)
        else $error("select flag lost inside frame");
    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.bus_done |=> (r_phase == qsb_pkg::PH_IDLE) && !r_sel_low)
        else $error("done tick did not return to idle");
`endif

endmodule

/* src/quad_spi_bus_bridge.sv */
// Quad SPI bus bridge: input register, frame sequencer and result register.
// Each transaction goes through the input register, then the result register.
// Throughput: one transaction per unstalled cycle; the sequencer steps once per transaction.
// Output stall holds both stages; the input register refills as the result is taken.
// Reset (synchronous, active low): idle phase, select high, clock polarity zero,
// command register back to its default, both stages empty.
module quad_spi_bus_bridge (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  qsb_pkg::t_in     i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output qsb_pkg::t_out    o_out_data,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata
);

    logic          r_in_valid, n_in_valid;
    qsb_pkg::t_in  r_in;
    logic          r_out_valid;
    qsb_pkg::t_out r_out;
    qsb_pkg::t_out w_result;
    logic          w_adv, w_fire, w_load;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_load     = i_in_valid && !o_in_stall;

    always_comb begin
        priority if (w_load) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    qsb_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_busy_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bus_busy |-> !r_out.chip_select_n)
        else $error("busy without select low");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bus_done |-> r_out.chip_select_n && !r_out.bus_busy)
        else $error("done inside a frame");
    a_word_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.bus_done |-> (r_out.read_word == 32'd0))
        else $error("read word outside done tick");
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("stage one dropped a transaction");
`endif

endmodule
